// ----- rtl/fsa_pkg.sv -----
// ----------------------------------------------------------------------------
// fsa_pkg
// Types, codes and constants shared by the funnel step-acceptance core and
// its floating-point unit.
// ----------------------------------------------------------------------------
package fsa_pkg;

    // double bit patterns
    localparam logic [63:0] DBL_ZERO  = 64'h0000_0000_0000_0000;
    localparam logic [63:0] DBL_ONE   = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] DBL_QNAN  = 64'hFFF8_0000_0000_0000;
    localparam logic [63:0] QUIET_BIT = 64'h0008_0000_0000_0000;

    // internal floating-point datapath
    localparam int NORM_W = 108;
    localparam int EXP_W  = 14;
    localparam int CHUNK_W = 14;

    typedef enum logic [1:0] {
        OP_JUDGE    = 2'd0,
        OP_RESET    = 2'd1,
        OP_RESUME   = 2'd2,
        OP_SET_FULL = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        VERDICT_REJECT   = 3'd0,
        VERDICT_ACCEPT_F = 3'd1,
        VERDICT_ACCEPT_H = 3'd2,
        VERDICT_RESTORE  = 3'd3,
        VERDICT_NOT_INIT = 3'd4,
        VERDICT_BAD_ARG  = 3'd5
    } verdict_t;

    typedef enum logic [3:0] {
        REG_TAU_BAR        = 4'd0,
        REG_KAPPA_BAR      = 4'd1,
        REG_FEAS_EPS       = 4'd2,
        REG_MIN_REJECTIONS = 4'd3,
        REG_SWITCH_DELTA   = 4'd4,
        REG_ARMIJO_SIGMA   = 4'd5,
        REG_SHRINK_BETA    = 4'd6,
        REG_BLEND_KAPPA    = 4'd7
    } reg_index_t;

    typedef enum logic {
        FPU_OP_MUL = 1'b0,
        FPU_OP_ADD = 1'b1
    } fpu_op_t;

    typedef enum logic [2:0] {
        FPU_IDLE,
        FPU_MULT,
        FPU_NORM,
        FPU_DENORM,
        FPU_ROUND
    } fpu_state_t;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_DISPATCH,
        SEQ_RST_MUL,
        SEQ_THR1,
        SEQ_THR2,
        SEQ_ARM1,
        SEQ_ARM2,
        SEQ_BETA,
        SEQ_BL1,
        SEQ_BL2,
        SEQ_BL3,
        SEQ_BL4,
        SEQ_EMIT
    } seq_state_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] obj_old;
        logic [63:0] obj_new;
        logic [63:0] viol_old;
        logic [63:0] viol_new;
        logic [63:0] pred_decrease;
        logic [7:0]  rejection_count;
        logic [63:0] violation_value;
    } in_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [63:0] funnel_width;
    } out_t;

    typedef struct packed {
        logic        start;
        fpu_op_t     op;
        logic        sub;
        logic [63:0] a;
        logic [63:0] b;
    } fpu_req_t;

    typedef struct packed {
        logic        done;
        logic        busy;
        logic [63:0] res;
    } fpu_rsp_t;

    function automatic logic fp_is_nan(input logic [63:0] x);
        return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
    endfunction

    function automatic logic fp_finite(input logic [63:0] x);
        return x[62:52] != 11'h7FF;
    endfunction

    // ordered a < b
    function automatic logic fp_lt(input logic [63:0] a, input logic [63:0] b);
        logic both_zero;
        logic r;
        both_zero = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
        if (fp_is_nan(a) || fp_is_nan(b) || both_zero) begin
            r = 1'b0;
        end else if (a[63] != b[63]) begin
            r = a[63];
        end else if (!a[63]) begin
            r = a[62:0] < b[62:0];
        end else begin
            r = a[62:0] > b[62:0];
        end
        return r;
    endfunction

    // ordered a <= b
    function automatic logic fp_le(input logic [63:0] a, input logic [63:0] b);
        logic eq;
        eq = !fp_is_nan(a) && !fp_is_nan(b) &&
             ((a == b) || ((a[62:0] == 63'd0) && (b[62:0] == 63'd0)));
        return eq || fp_lt(a, b);
    endfunction

endpackage

// ----- rtl/fsa_fpu.sv -----
// ----------------------------------------------------------------------------
// fsa_fpu
// Shared double-precision multiply / add unit, round to nearest even.
// Mantissa product in four 14-bit slices, then an iterative normalize,
// subnormal shift and a final rounding step.
// ----------------------------------------------------------------------------
module fsa_fpu
    import fsa_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  fpu_req_t req,
    output fpu_rsp_t rsp
);

    localparam logic signed [EXP_W-1:0] BIAS_LSB = EXP_W'(1075);
    localparam logic signed [EXP_W-1:0] EXP_MIN  = -EXP_W'(1074);
    localparam logic signed [EXP_W-1:0] LSB_OFS  = EXP_W'(NORM_W - 53);
    localparam logic signed [EXP_W-1:0] EXP_INF  = EXP_W'(2047);
    localparam int PART_W = 53 + CHUNK_W;

    fpu_state_t                state_reg, state_next;
    logic                      sign_reg, sign_next;
    logic signed [EXP_W-1:0]   exp_reg, exp_next;
    logic [NORM_W-1:0]         norm_reg, norm_next;
    logic [52:0]               ma_reg, ma_next;
    logic [4*CHUNK_W-1:0]      mb_reg, mb_next;
    logic [1:0]                chunk_reg, chunk_next;
    logic [63:0]               res_reg, res_next;
    logic                      done_reg, done_next;

    // operand decode
    logic [63:0] op_a, op_b, b_eff;
    logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [52:0] ma, mb;
    logic signed [EXP_W-1:0] ea, eb;

    // addition alignment
    logic a_big;
    logic [52:0] mx, my;
    logic signed [EXP_W-1:0] ex, ey, ed;
    logic sx, sy;
    logic [55:0] mx_ext, my_ext, my_sh, my_mask;
    logic my_st;
    logic [56:0] sum;

    // multiply slice
    logic [CHUNK_W-1:0] mb_chunk;
    logic [PART_W-1:0]  part;
    logic [NORM_W-1:0]  part_sh;

    // subnormal shift and rounding
    logic signed [EXP_W-1:0] lsb_exp, need, lsb_r, biased;
    logic [52:0] kept, r53;
    logic [53:0] r54;
    logic guard, sticky, inc;

    always_comb begin
        op_a   = req.a;
        op_b   = req.b;
        b_eff  = {op_b[63] ^ req.sub, op_b[62:0]};
        a_nan  = fp_is_nan(op_a);
        b_nan  = fp_is_nan(op_b);
        a_inf  = (op_a[62:52] == 11'h7FF) && (op_a[51:0] == 52'd0);
        b_inf  = (op_b[62:52] == 11'h7FF) && (op_b[51:0] == 52'd0);
        a_zero = op_a[62:0] == 63'd0;
        b_zero = op_b[62:0] == 63'd0;
        ma     = {op_a[62:52] != 11'd0, op_a[51:0]};
        mb     = {op_b[62:52] != 11'd0, op_b[51:0]};
        ea     = (op_a[62:52] == 11'd0) ? EXP_W'(1) - BIAS_LSB
                                        : $signed({3'b000, op_a[62:52]}) - BIAS_LSB;
        eb     = (op_b[62:52] == 11'd0) ? EXP_W'(1) - BIAS_LSB
                                        : $signed({3'b000, op_b[62:52]}) - BIAS_LSB;

        // larger magnitude first
        a_big  = op_a[62:0] >= b_eff[62:0];
        mx     = a_big ? ma : mb;
        my     = a_big ? mb : ma;
        ex     = a_big ? ea : eb;
        ey     = a_big ? eb : ea;
        sx     = a_big ? op_a[63] : b_eff[63];
        sy     = a_big ? b_eff[63] : op_a[63];
        ed     = ex - ey;
        mx_ext = {mx, 3'b000};
        my_ext = {my, 3'b000};
        if (ed >= EXP_W'(56)) begin
            my_sh   = 56'd0;
            my_mask = '1;
        end else begin
            my_sh   = my_ext >> ed[5:0];
            my_mask = (56'd1 << ed[5:0]) - 56'd1;
        end
        my_st = |(my_ext & my_mask);
        if (sx == sy) begin
            sum = {1'b0, mx_ext} + {1'b0, my_sh | {55'd0, my_st}};
        end else begin
            sum = {1'b0, mx_ext} - {1'b0, my_sh | {55'd0, my_st}};
        end

        mb_chunk = mb_reg[chunk_reg*CHUNK_W +: CHUNK_W];
        part     = ma_reg * mb_chunk;
        part_sh  = {{(NORM_W-PART_W){1'b0}}, part} << (chunk_reg * CHUNK_W);

        lsb_exp = exp_reg + LSB_OFS;
        need    = EXP_MIN - lsb_exp;

        kept   = norm_reg[NORM_W-1 -: 53];
        guard  = norm_reg[NORM_W-54];
        sticky = |norm_reg[NORM_W-55:0];
        inc    = guard & (sticky | kept[0]);
        r54    = {1'b0, kept} + {53'd0, inc};
        if (r54[53]) begin
            r53   = r54[53:1];
            lsb_r = lsb_exp + EXP_W'(1);
        end else begin
            r53   = r54[52:0];
            lsb_r = lsb_exp;
        end
        biased = lsb_r + EXP_W'(52 + 1023);
    end

    always_comb begin
        state_next = state_reg;
        sign_next  = sign_reg;
        exp_next   = exp_reg;
        norm_next  = norm_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        chunk_next = chunk_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        case (state_reg)
            FPU_IDLE: begin
                if (req.start) begin
                    if (a_nan) begin
                        res_next  = op_a | QUIET_BIT;
                        done_next = 1'b1;
                    end else if (b_nan) begin
                        res_next  = op_b | QUIET_BIT;
                        done_next = 1'b1;
                    end else if (req.op == FPU_OP_MUL) begin
                        if ((a_inf && b_zero) || (a_zero && b_inf)) begin
                            res_next  = DBL_QNAN;
                            done_next = 1'b1;
                        end else if (a_inf || b_inf) begin
                            res_next  = {op_a[63] ^ op_b[63], 11'h7FF, 52'd0};
                            done_next = 1'b1;
                        end else begin
                            ma_next    = ma;
                            mb_next    = {3'b000, mb};
                            exp_next   = ea + eb;
                            sign_next  = op_a[63] ^ op_b[63];
                            norm_next  = '0;
                            chunk_next = 2'd0;
                            state_next = FPU_MULT;
                        end
                    end else begin
                        if (a_inf && b_inf && (op_a[63] != b_eff[63])) begin
                            res_next  = DBL_QNAN;
                            done_next = 1'b1;
                        end else if (a_inf) begin
                            res_next  = op_a;
                            done_next = 1'b1;
                        end else if (b_inf) begin
                            res_next  = b_eff;
                            done_next = 1'b1;
                        end else if (sum == 57'd0) begin
                            // exact cancellation gives +0 unless both are -0
                            res_next  = {sx & sy, 63'd0};
                            done_next = 1'b1;
                        end else begin
                            norm_next  = {{(NORM_W-57){1'b0}}, sum};
                            exp_next   = ex - EXP_W'(3);
                            sign_next  = sx;
                            state_next = FPU_NORM;
                        end
                    end
                end
            end
            FPU_MULT: begin
                norm_next  = norm_reg + part_sh;
                chunk_next = chunk_reg + 2'd1;
                if (chunk_reg == 2'd3) begin
                    state_next = FPU_NORM;
                end
            end
            FPU_NORM: begin
                if (norm_reg == '0) begin
                    res_next   = {sign_reg, 63'd0};
                    done_next  = 1'b1;
                    state_next = FPU_IDLE;
                end else if (norm_reg[NORM_W-1]) begin
                    state_next = FPU_DENORM;
                end else if (norm_reg[NORM_W-1 -: 16] == 16'd0) begin
                    norm_next = norm_reg << 16;
                    exp_next  = exp_reg - EXP_W'(16);
                end else begin
                    norm_next = norm_reg << 1;
                    exp_next  = exp_reg - EXP_W'(1);
                end
            end
            FPU_DENORM: begin
                if (need <= EXP_W'(0)) begin
                    state_next = FPU_ROUND;
                end else if (need > EXP_W'(NORM_W)) begin
                    // far below the smallest subnormal: only sticky survives
                    norm_next  = {{(NORM_W-1){1'b0}}, 1'b1};
                    exp_next   = EXP_MIN - LSB_OFS;
                    state_next = FPU_ROUND;
                end else begin
                    norm_next = {1'b0, norm_reg[NORM_W-1:1]} |
                                {{(NORM_W-1){1'b0}}, norm_reg[0]};
                    exp_next  = exp_reg + EXP_W'(1);
                end
            end
            FPU_ROUND: begin
                if (!r53[52]) begin
                    res_next = {sign_reg, 11'd0, r53[51:0]};
                end else if (biased >= EXP_INF) begin
                    res_next = {sign_reg, 11'h7FF, 52'd0};
                end else begin
                    res_next = {sign_reg, biased[10:0], r53[51:0]};
                end
                done_next  = 1'b1;
                state_next = FPU_IDLE;
            end
            default: begin
                state_next = FPU_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FPU_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        sign_reg  <= sign_next;
        exp_reg   <= exp_next;
        norm_reg  <= norm_next;
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
        chunk_reg <= chunk_next;
        res_reg   <= res_next;
    end

    assign rsp.done = done_reg;
    assign rsp.busy = state_reg != FPU_IDLE;
    assign rsp.res  = res_reg;

endmodule

// ----- rtl/funnel_step_acceptance_core.sv -----
// ----------------------------------------------------------------------------
// funnel_step_acceptance_core
// Funnel step-acceptance test on double bit patterns, one result per item.
// Sequence: an accepted item passes a dispatch state, then goes to the emit
//   state at once for ops that need no arithmetic, or waits on each double
//   multiply or add on the shared unit, which takes longer when its result
//   is subnormal; a judge that updates the width runs seven such operations.
// Throughput: one transaction at a time, the next is taken back in idle.
// Reset: synchronous active-low aresetn clears width, flags, sequencer state and config registers.
// ----------------------------------------------------------------------------
module funnel_step_acceptance_core
    import fsa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data
);

    // configuration registers
    logic [63:0] tau_bar_reg, kappa_bar_reg, feas_eps_reg, switch_delta_reg;
    logic [63:0] armijo_sigma_reg, shrink_beta_reg, blend_kappa_reg;
    logic [7:0]  min_rejections_reg;

    // sequencer and block state
    seq_state_t  state_reg, state_next;
    in_t         in_reg, in_next;
    logic [63:0] width_reg, width_next;
    logic        init_reg, init_next;
    logic        full_step_reg, full_step_next;
    verdict_t    verdict_reg, verdict_next;
    logic [63:0] tmp_reg, tmp_next;          // held product between fpu ops
    logic [63:0] blend_h_reg, blend_h_next;  // violation fed into the blend
    logic        resume_reg, resume_next;    // blend came from a resume op
    logic        m_valid_reg, m_valid_next;
    out_t        m_data_reg, m_data_next;

    fpu_req_t fpu_req;
    fpu_rsp_t fpu_rsp;

    // judge decodes
    logic all_finite, funnel_ok, restore_sig, hv_good;

    fsa_fpu u_fpu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (fpu_req),
        .rsp     (fpu_rsp)
    );

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tau_bar_reg        <= '0;
            kappa_bar_reg      <= '0;
            feas_eps_reg       <= '0;
            min_rejections_reg <= '0;
            switch_delta_reg   <= '0;
            armijo_sigma_reg   <= '0;
            shrink_beta_reg    <= '0;
            blend_kappa_reg    <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_TAU_BAR:        tau_bar_reg        <= cfg_data;
                REG_KAPPA_BAR:      kappa_bar_reg      <= cfg_data;
                REG_FEAS_EPS:       feas_eps_reg       <= cfg_data;
                REG_MIN_REJECTIONS: min_rejections_reg <= cfg_data[7:0];
                REG_SWITCH_DELTA:   switch_delta_reg   <= cfg_data;
                REG_ARMIJO_SIGMA:   armijo_sigma_reg   <= cfg_data;
                REG_SHRINK_BETA:    shrink_beta_reg    <= cfg_data;
                REG_BLEND_KAPPA:    blend_kappa_reg    <= cfg_data;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    always_comb begin
        all_finite = fp_finite(in_reg.obj_old) && fp_finite(in_reg.obj_new) &&
                     fp_finite(in_reg.viol_old) && fp_finite(in_reg.viol_new) &&
                     fp_finite(in_reg.pred_decrease);
        funnel_ok  = fp_le(in_reg.viol_new, width_reg);
        // infeasible-stationary signature for restoration
        restore_sig = fp_lt(feas_eps_reg, in_reg.viol_old) &&
                      fp_le(in_reg.pred_decrease, DBL_ZERO) &&
                      fp_le(in_reg.viol_old, in_reg.viol_new) &&
                      (in_reg.rejection_count >= min_rejections_reg);
        // negative zero counts as a good violation
        hv_good    = fp_finite(in_reg.violation_value) &&
                     fp_le(DBL_ZERO, in_reg.violation_value);
    end

    always_comb begin
        state_next     = state_reg;
        in_next        = in_reg;
        width_next     = width_reg;
        init_next      = init_reg;
        full_step_next = full_step_reg;
        verdict_next   = verdict_reg;
        tmp_next       = tmp_reg;
        blend_h_next   = blend_h_reg;
        resume_next    = resume_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        fpu_req        = '0;
        s_ready        = state_reg == SEQ_IDLE;

        case (state_reg)
            SEQ_IDLE: begin
                if (s_valid) begin
                    in_next    = s_data;
                    state_next = SEQ_DISPATCH;
                end
            end
            SEQ_DISPATCH: begin
                case (in_reg.op)
                    OP_RESET: begin
                        if (!hv_good) begin
                            verdict_next = VERDICT_BAD_ARG;
                            state_next   = SEQ_EMIT;
                        end else begin
                            fpu_req.start = 1'b1;
                            fpu_req.op    = FPU_OP_MUL;
                            fpu_req.a     = kappa_bar_reg;
                            fpu_req.b     = in_reg.violation_value;
                            state_next    = SEQ_RST_MUL;
                        end
                    end
                    OP_RESUME: begin
                        if (!init_reg) begin
                            verdict_next = VERDICT_NOT_INIT;
                            state_next   = SEQ_EMIT;
                        end else if (!hv_good) begin
                            verdict_next = VERDICT_BAD_ARG;
                            state_next   = SEQ_EMIT;
                        end else begin
                            blend_h_next  = in_reg.violation_value;
                            resume_next   = 1'b1;
                            fpu_req.start = 1'b1;
                            fpu_req.op    = FPU_OP_ADD;
                            fpu_req.sub   = 1'b1;
                            fpu_req.a     = DBL_ONE;
                            fpu_req.b     = blend_kappa_reg;
                            state_next    = SEQ_BL1;
                        end
                    end
                    OP_SET_FULL: begin
                        full_step_next = 1'b1;
                        verdict_next   = VERDICT_REJECT;
                        state_next     = SEQ_EMIT;
                    end
                    default: begin
                        // judge
                        if (!init_reg) begin
                            verdict_next = VERDICT_NOT_INIT;
                            state_next   = SEQ_EMIT;
                        end else if (!all_finite) begin
                            verdict_next = VERDICT_REJECT;
                            state_next   = SEQ_EMIT;
                        end else if (full_step_reg) begin
                            verdict_next = VERDICT_ACCEPT_F;
                            state_next   = SEQ_EMIT;
                        end else if (!funnel_ok) begin
                            verdict_next = restore_sig ? VERDICT_RESTORE : VERDICT_REJECT;
                            state_next   = SEQ_EMIT;
                        end else begin
                            // switching threshold delta * h_old * h_old
                            fpu_req.start = 1'b1;
                            fpu_req.op    = FPU_OP_MUL;
                            fpu_req.a     = switch_delta_reg;
                            fpu_req.b     = in_reg.viol_old;
                            state_next    = SEQ_THR1;
                        end
                    end
                endcase
            end
            SEQ_RST_MUL: begin
                if (fpu_rsp.done) begin
                    width_next   = fp_lt(tau_bar_reg, fpu_rsp.res) ? fpu_rsp.res
                                                                   : tau_bar_reg;
                    init_next    = 1'b1;
                    verdict_next = VERDICT_REJECT;
                    state_next   = SEQ_EMIT;
                end
            end
            SEQ_THR1: begin
                if (fpu_rsp.done) begin
                    fpu_req.start = 1'b1;
                    fpu_req.op    = FPU_OP_MUL;
                    fpu_req.a     = fpu_rsp.res;
                    fpu_req.b     = in_reg.viol_old;
                    state_next    = SEQ_THR2;
                end
            end
            SEQ_THR2: begin
                if (fpu_rsp.done) begin
                    fpu_req.start = 1'b1;
                    fpu_req.op    = FPU_OP_MUL;
                    if (fp_le(fpu_rsp.res, in_reg.pred_decrease)) begin
                        // f-type step, armijo bound sigma * pred
                        fpu_req.a  = armijo_sigma_reg;
                        fpu_req.b  = in_reg.pred_decrease;
                        state_next = SEQ_ARM1;
                    end else begin
                        // h-type step, bound beta * width
                        fpu_req.a  = shrink_beta_reg;
                        fpu_req.b  = width_reg;
                        state_next = SEQ_BETA;
                    end
                end
            end
            SEQ_ARM1: begin
                if (fpu_rsp.done) begin
                    tmp_next      = fpu_rsp.res;
                    fpu_req.start = 1'b1;
                    fpu_req.op    = FPU_OP_ADD;
                    fpu_req.sub   = 1'b1;
                    fpu_req.a     = in_reg.obj_old;
                    fpu_req.b     = in_reg.obj_new;
                    state_next    = SEQ_ARM2;
                end
            end
            SEQ_ARM2: begin
                if (fpu_rsp.done) begin
                    verdict_next = fp_le(tmp_reg, fpu_rsp.res) ? VERDICT_ACCEPT_F
                                                               : VERDICT_REJECT;
                    state_next   = SEQ_EMIT;
                end
            end
            SEQ_BETA: begin
                if (fpu_rsp.done) begin
                    if (fp_le(in_reg.viol_new, fpu_rsp.res)) begin
                        blend_h_next  = in_reg.viol_new;
                        resume_next   = 1'b0;
                        fpu_req.start = 1'b1;
                        fpu_req.op    = FPU_OP_ADD;
                        fpu_req.sub   = 1'b1;
                        fpu_req.a     = DBL_ONE;
                        fpu_req.b     = blend_kappa_reg;
                        state_next    = SEQ_BL1;
                    end else begin
                        verdict_next = VERDICT_REJECT;
                        state_next   = SEQ_EMIT;
                    end
                end
            end
            // width blend (1 - k) * h + k * w
            SEQ_BL1: begin
                if (fpu_rsp.done) begin
                    fpu_req.start = 1'b1;
                    fpu_req.op    = FPU_OP_MUL;
                    fpu_req.a     = fpu_rsp.res;
                    fpu_req.b     = blend_h_reg;
                    state_next    = SEQ_BL2;
                end
            end
            SEQ_BL2: begin
                if (fpu_rsp.done) begin
                    tmp_next      = fpu_rsp.res;
                    fpu_req.start = 1'b1;
                    fpu_req.op    = FPU_OP_MUL;
                    fpu_req.a     = blend_kappa_reg;
                    fpu_req.b     = width_reg;
                    state_next    = SEQ_BL3;
                end
            end
            SEQ_BL3: begin
                if (fpu_rsp.done) begin
                    fpu_req.start = 1'b1;
                    fpu_req.op    = FPU_OP_ADD;
                    fpu_req.a     = tmp_reg;
                    fpu_req.b     = fpu_rsp.res;
                    state_next    = SEQ_BL4;
                end
            end
            SEQ_BL4: begin
                if (fpu_rsp.done) begin
                    width_next = fpu_rsp.res;
                    if (resume_reg) begin
                        full_step_next = 1'b0;
                        verdict_next   = VERDICT_REJECT;
                    end else begin
                        verdict_next = VERDICT_ACCEPT_H;
                    end
                    state_next = SEQ_EMIT;
                end
            end
            SEQ_EMIT: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_ready) begin
                    m_data_next.verdict      = verdict_reg;
                    m_data_next.funnel_width = width_reg;
                    m_valid_next             = 1'b1;
                    state_next               = SEQ_IDLE;
                end
            end
            default: begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= SEQ_IDLE;
            width_reg     <= '0;
            init_reg      <= 1'b0;
            full_step_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            width_reg     <= width_next;
            init_reg      <= init_next;
            full_step_reg <= full_step_next;
            m_valid_reg   <= m_valid_next;
        end
        in_reg      <= in_next;
        verdict_reg <= verdict_next;
        tmp_reg     <= tmp_next;
        blend_h_reg <= blend_h_next;
        resume_reg  <= resume_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // a new fpu operation is only issued to an idle unit
    a_fpu_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        fpu_req.start |-> !fpu_rsp.busy)
        else $error("fpu started while busy");

    // an fpu result only arrives while the sequencer waits on one
    a_fpu_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        fpu_rsp.done |-> (state_reg == SEQ_RST_MUL || state_reg == SEQ_THR1 ||
                          state_reg == SEQ_THR2 || state_reg == SEQ_ARM1 ||
                          state_reg == SEQ_ARM2 || state_reg == SEQ_BETA ||
                          state_reg == SEQ_BL1 || state_reg == SEQ_BL2 ||
                          state_reg == SEQ_BL3 || state_reg == SEQ_BL4))
        else $error("fpu result with no consumer");

    // set full-step transaction raises the flag once it has been dispatched
    a_set_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.op == OP_SET_FULL) |=> ##1 full_step_reg)
        else $error("full-step flag not set");
`endif

endmodule

// ----- tb/tb_funnel_step_acceptance_core.sv -----
// ----------------------------------------------------------------------------
// tb_funnel_step_acceptance_core
// Self-checking testbench for the funnel step-acceptance core. A directed
// table covers the edge cases: ops issued before reset, bad violation values,
// full-step mode and the restoration signature. It is followed by several
// register settings, from nominal solver values to zeros, infinities and
// NaNs. Each setting gets random transactions, most of them solver-like trial
// points sized against the predicted funnel width. Every result is checked
// against an in-bench double-precision predictor, with random gaps on both
// sides of the core.
// ----------------------------------------------------------------------------
module tb_funnel_step_acceptance_core;
    import fsa_pkg::*;

    localparam int N_PHASES    = 7;
    localparam int PHASE_ITEMS = 262;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_index = '0;
    logic [63:0] cfg_data  = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_t         s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_t        m_data;

    funnel_step_acceptance_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // predictor copy of the registers and state
    logic [63:0] tau_bar_q, kappa_bar_q, feas_eps_q, switch_delta_q;
    logic [63:0] armijo_sigma_q, shrink_beta_q, blend_kappa_q;
    logic [7:0]  min_rej_q;
    logic [63:0] width_q;
    logic        init_q;
    logic        full_step_q;

    out_t pending_verdicts[$];
    int   mismatch_count = 0;
    bit   no_idle        = 1'b0;

    typedef struct {
        in_t         item;
        bit          typed;
        verdict_t    verdict;
        logic [63:0] width;
    } dir_row_t;

    dir_row_t dir_rows[$];

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #200_000_000;
        $display("funnel_step_acceptance_core regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    function automatic bit is_finite(logic [63:0] x);
        return x[62:52] != 11'h7FF;
    endfunction

    function automatic bit is_nan_bits(logic [63:0] x);
        return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
    endfunction

    // negative, NaN or infinite violations are refused
    function automatic bit violation_ok(logic [63:0] x);
        return is_finite(x) && ($bitstoreal(x) >= 0.0);
    endfunction

    function automatic logic [63:0] blend_width(real h, real w);
        real k;
        k = $bitstoreal(blend_kappa_q);
        return $realtobits((1.0 - k) * h + k * w);
    endfunction

    function automatic verdict_t judge_trial(in_t d);
        real f_old, f_new, h_old, h_new, pred, w, thr;
        bit  restore;
        if (!init_q) return VERDICT_NOT_INIT;
        if (!is_finite(d.obj_old) || !is_finite(d.obj_new) || !is_finite(d.viol_old) ||
            !is_finite(d.viol_new) || !is_finite(d.pred_decrease))
            return VERDICT_REJECT;
        if (full_step_q) return VERDICT_ACCEPT_F;
        f_old = $bitstoreal(d.obj_old);
        f_new = $bitstoreal(d.obj_new);
        h_old = $bitstoreal(d.viol_old);
        h_new = $bitstoreal(d.viol_new);
        pred  = $bitstoreal(d.pred_decrease);
        w     = $bitstoreal(width_q);
        // outside the funnel: restoration only with the infeasible-stationary signature
        if (!(h_new <= w)) begin
            restore = (h_old > $bitstoreal(feas_eps_q)) && (pred <= 0.0) &&
                      (h_new >= h_old) && (d.rejection_count >= min_rej_q);
            return restore ? VERDICT_RESTORE : VERDICT_REJECT;
        end
        thr = $bitstoreal(switch_delta_q) * h_old;
        thr = thr * h_old;
        // switching condition holds: f-type step, armijo test
        if (pred >= thr)
            return (f_old - f_new >= $bitstoreal(armijo_sigma_q) * pred) ?
                   VERDICT_ACCEPT_F : VERDICT_REJECT;
        // h-type step must shrink below beta times the width
        if (h_new <= $bitstoreal(shrink_beta_q) * w) begin
            width_q = blend_width(h_new, w);
            return VERDICT_ACCEPT_H;
        end
        return VERDICT_REJECT;
    endfunction

    function automatic out_t funnel_predict(in_t d);
        out_t r;
        real  tau, scaled;
        r.verdict = VERDICT_REJECT;
        case (op_t'(d.op))
            OP_JUDGE: r.verdict = judge_trial(d);
            OP_RESET: begin
                if (!violation_ok(d.violation_value)) begin
                    r.verdict = VERDICT_BAD_ARG;
                end else begin
                    tau     = $bitstoreal(tau_bar_q);
                    scaled  = $bitstoreal(kappa_bar_q) * $bitstoreal(d.violation_value);
                    width_q = (tau < scaled) ? $realtobits(scaled) : tau_bar_q;
                    init_q  = 1'b1;
                end
            end
            OP_RESUME: begin
                if (!init_q) begin
                    r.verdict = VERDICT_NOT_INIT;
                end else if (!violation_ok(d.violation_value)) begin
                    r.verdict = VERDICT_BAD_ARG;
                end else begin
                    width_q     = blend_width($bitstoreal(d.violation_value),
                                              $bitstoreal(width_q));
                    full_step_q = 1'b0;
                end
            end
            default: full_step_q = 1'b1;
        endcase
        r.funnel_width = width_q;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    // a NaN width is matched by any NaN: payload and sign of a generated NaN
    // depend on operand order inside the multiply-add unit
    function automatic bit width_matches(logic [63:0] want, logic [63:0] got);
        if (is_nan_bits(want)) return is_nan_bits(got);
        return want === got;
    endfunction

    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transaction: verdict %0d width %h",
                             m_data.verdict, m_data.funnel_width);
            end else begin
                want = pending_verdicts.pop_front();
                if (m_data.verdict !== want.verdict ||
                    !width_matches(want.funnel_width, m_data.funnel_width)) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: verdict exp %0d got %0d, width exp %h got %h",
                                 want.verdict, m_data.verdict,
                                 want.funnel_width, m_data.funnel_width);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result-side backpressure
    // ------------------------------------------------------------------------
    int stall_left = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else begin
            stall_left <= pick_gap();
            m_ready    <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    // valid stays high across back-to-back writes; the caller drops it after the last
    task automatic write_reg(reg_index_t idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_TAU_BAR:        tau_bar_q      = value;
            REG_KAPPA_BAR:      kappa_bar_q    = value;
            REG_FEAS_EPS:       feas_eps_q     = value;
            REG_MIN_REJECTIONS: min_rej_q      = value[7:0];
            REG_SWITCH_DELTA:   switch_delta_q = value;
            REG_ARMIJO_SIGMA:   armijo_sigma_q = value;
            REG_SHRINK_BETA:    shrink_beta_q  = value;
            default:            blend_kappa_q  = value;
        endcase
    endtask

    // every transaction makes a result, so an empty queue means the core is idle
    task automatic drain();
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // one transaction; valid stays high when the next one follows with no gap
    task automatic send_item(in_t d, bit typed, out_t typed_exp);
        out_t p;
        int   gap;
        s_valid <= 1'b1;
        s_data  <= d;
        do @(posedge aclk); while (!s_ready);
        p = funnel_predict(d);
        pending_verdicts.push_back(typed ? typed_exp : p);
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic real unit_rand();
        return real'($urandom) / 4294967296.0;
    endfunction

    function automatic logic [63:0] rand_bits();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] dbl(real x);
        return $realtobits(x);
    endfunction

    function automatic logic [63:0] odd_value();
        case ($urandom_range(0, 7))
            0: return DBL_QNAN;
            1: return 64'h7FF0_0000_0000_0000;
            2: return 64'hFFF0_0000_0000_0000;
            3: return dbl(-1.0);
            4: return 64'h7FEF_FFFF_FFFF_FFFF;
            5: return 64'h0000_0000_0000_0001;
            6: return 64'h8000_0000_0000_0000;
            default: return rand_bits();
        endcase
    endfunction

    function automatic in_t make_item(op_t op, logic [63:0] fo, logic [63:0] fn,
                                      logic [63:0] ho, logic [63:0] hn,
                                      logic [63:0] pr, logic [7:0] rc,
                                      logic [63:0] hv);
        in_t d;
        d.op              = op;
        d.obj_old         = fo;
        d.obj_new         = fn;
        d.viol_old        = ho;
        d.viol_new        = hn;
        d.pred_decrease   = pr;
        d.rejection_count = rc;
        d.violation_value = hv;
        return d;
    endfunction

    function automatic void add_row(in_t d, bit typed = 1'b0,
                                    verdict_t v = VERDICT_REJECT,
                                    logic [63:0] w = '0);
        dir_row_t row;
        row.item    = d;
        row.typed   = typed;
        row.verdict = v;
        row.width   = w;
        dir_rows.push_back(row);
    endfunction

    // trial point sized against the current width so every branch is reached
    function automatic in_t solver_item();
        in_t d;
        real w, ho, hn, pr, fo;
        int  r;
        w = $bitstoreal(width_q);
        if (!is_finite(width_q) || !(w > 0.0) || w > 1.0e100) w = 1.0;
        ho = w * unit_rand() * 1.5;
        hn = ($urandom_range(0, 3) == 0) ? ho * (1.0 + unit_rand()) : w * unit_rand() * 1.3;
        r  = $urandom_range(0, 3);
        pr = (r == 0) ? -unit_rand() : (r == 1) ? 0.0 :
             (r == 2) ? unit_rand() * 1.0e-3 : unit_rand() * 10.0;
        fo = (unit_rand() - 0.5) * 100.0;
        d  = make_item(OP_JUDGE, dbl(fo), dbl(fo - (unit_rand() - 0.2) * pr * 2.0),
                       dbl(ho), dbl(hn), dbl(pr),
                       ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 255)) :
                                                     8'(min_rej_q + $urandom_range(0, 2) - 1),
                       rand_bits());
        if ($urandom_range(0, 19) == 0) d.obj_new = odd_value();
        return d;
    endfunction

    function automatic in_t random_item();
        in_t         d;
        int          r;
        logic [63:0] hv;
        r  = $urandom_range(0, 99);
        hv = ($urandom_range(0, 9) == 0) ? odd_value() :
             ($urandom_range(0, 9) == 0) ? DBL_ZERO : dbl(unit_rand() * 5.0);
        d  = make_item(OP_JUDGE, rand_bits(), rand_bits(), rand_bits(), rand_bits(),
                       rand_bits(), 8'($urandom_range(0, 255)), rand_bits());
        if (r < 62) begin
            d = solver_item();
        end else if (r < 70) begin
            d.op = OP_RESET;
            d.violation_value = hv;
        end else if (r < 78) begin
            d.op = OP_RESUME;
            d.violation_value = hv;
        end else if (r < 82) begin
            d.op = OP_SET_FULL;
        end else begin
            // raw noise on every field
            d.op = op_t'($urandom_range(0, 3));
        end
        return d;
    endfunction

    task automatic load_setting(int kind);
        logic [63:0] v[8];
        case (kind)
            1: foreach (v[i]) v[i] = DBL_ZERO;
            2: foreach (v[i]) v[i] = '1;
            4: foreach (v[i]) v[i] = odd_value();
            default: begin
                v[REG_TAU_BAR]        = dbl(0.1 + unit_rand() * 10.0);
                v[REG_KAPPA_BAR]      = dbl(1.0 + unit_rand() * 9.0);
                v[REG_FEAS_EPS]       = dbl(1.0e-4 + unit_rand() * 0.1);
                v[REG_MIN_REJECTIONS] = 64'($urandom_range(0, 8));
                v[REG_SWITCH_DELTA]   = dbl(1.0e-4 + unit_rand());
                v[REG_ARMIJO_SIGMA]   = dbl(1.0e-4 + unit_rand() * 0.5);
                v[REG_SHRINK_BETA]    = dbl(0.5 + unit_rand() * 0.49);
                v[REG_BLEND_KAPPA]    = dbl(0.1 + unit_rand() * 0.8);
            end
        endcase
        if (kind == 2) v[REG_MIN_REJECTIONS] = 64'd255;
        for (int i = 0; i < 8; i++) write_reg(reg_index_t'(i), v[i]);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        out_t exp_row;
        tau_bar_q = '0; kappa_bar_q = '0; feas_eps_q = '0; switch_delta_q = '0;
        armijo_sigma_q = '0; shrink_beta_q = '0; blend_kappa_q = '0; min_rej_q = '0;
        width_q = '0; init_q = 1'b0; full_step_q = 1'b0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed setting: w0 = max(1, 10*h0)
        write_reg(REG_TAU_BAR,        dbl(1.0));
        write_reg(REG_KAPPA_BAR,      dbl(10.0));
        write_reg(REG_FEAS_EPS,       dbl(0.5));
        write_reg(REG_MIN_REJECTIONS, 64'd3);
        write_reg(REG_SWITCH_DELTA,   dbl(1.0));
        write_reg(REG_ARMIJO_SIGMA,   dbl(0.1));
        write_reg(REG_SHRINK_BETA,    dbl(0.5));
        write_reg(REG_BLEND_KAPPA,    dbl(0.5));
        cfg_valid <= 1'b0;

        // judge and resume before any reset op
        add_row(make_item(OP_JUDGE, '0, '0, '0, '0, '0, 8'd0, '0),
                1'b1, VERDICT_NOT_INIT, DBL_ZERO);
        add_row(make_item(OP_RESUME, '0, '0, '0, '0, '0, 8'd0, dbl(1.0)),
                1'b1, VERDICT_NOT_INIT, DBL_ZERO);
        // bad h0 values leave the state alone
        add_row(make_item(OP_RESET, '0, '0, '0, '0, '0, 8'd0, DBL_QNAN),
                1'b1, VERDICT_BAD_ARG, DBL_ZERO);
        add_row(make_item(OP_RESET, '0, '0, '0, '0, '0, 8'd0, dbl(-1.0)),
                1'b1, VERDICT_BAD_ARG, DBL_ZERO);
        add_row(make_item(OP_RESET, '0, '0, '0, '0, '0, 8'd0, 64'h7FF0_0000_0000_0000),
                1'b1, VERDICT_BAD_ARG, DBL_ZERO);
        // tau_bar wins, then kappa_bar*h0 wins
        add_row(make_item(OP_RESET, '1, '1, '1, '1, '1, 8'hFF, DBL_ZERO),
                1'b1, VERDICT_REJECT, DBL_ONE);
        add_row(make_item(OP_RESET, '0, '0, '0, '0, '0, 8'd0, dbl(2.0)),
                1'b1, VERDICT_REJECT, 64'h4034_0000_0000_0000);
        // non-finite objective rejects
        add_row(make_item(OP_JUDGE, 64'h7FF0_0000_0000_0000, dbl(1.0), dbl(1.0), dbl(1.0),
                          dbl(1.0), 8'd0, '0),
                1'b1, VERDICT_REJECT, 64'h4034_0000_0000_0000);
        // outside funnel with and without enough rejections
        add_row(make_item(OP_JUDGE, dbl(1.0), dbl(1.0), dbl(1.0), dbl(25.0), dbl(-1.0),
                          8'hFF, '0));
        add_row(make_item(OP_JUDGE, dbl(1.0), dbl(1.0), dbl(1.0), dbl(25.0), dbl(-1.0),
                          8'd0, '0));
        // f-type pass and fail
        add_row(make_item(OP_JUDGE, dbl(5.0), dbl(4.0), dbl(0.1), dbl(1.0), dbl(1.0),
                          8'd0, '0));
        add_row(make_item(OP_JUDGE, dbl(5.0), dbl(4.95), dbl(0.1), dbl(1.0), dbl(1.0),
                          8'd0, '0));
        // h-type pass blends the width, then a step outside the narrowed funnel fails
        add_row(make_item(OP_JUDGE, dbl(5.0), dbl(5.0), dbl(3.0), dbl(5.0), DBL_ZERO,
                          8'd0, '0));
        add_row(make_item(OP_JUDGE, dbl(5.0), dbl(5.0), dbl(3.0), dbl(14.0), DBL_ZERO,
                          8'd0, '0));
        // full-step mode accepts anything finite, survives reset
        add_row(make_item(OP_SET_FULL, '1, '1, '1, '1, '1, 8'hFF, '1));
        add_row(make_item(OP_JUDGE, dbl(1.0), dbl(9.0), dbl(1.0), dbl(1.0e30), dbl(-5.0),
                          8'd0, '0));
        add_row(make_item(OP_RESET, '0, '0, '0, '0, '0, 8'd0, dbl(0.5)));
        add_row(make_item(OP_JUDGE, dbl(1.0), dbl(9.0), dbl(1.0), dbl(1.0e30), dbl(-5.0),
                          8'd0, '0));
        add_row(make_item(OP_RESUME, '0, '0, '0, '0, '0, 8'd0, DBL_QNAN));
        add_row(make_item(OP_RESUME, '0, '0, '0, '0, '0, 8'd0, 64'h8000_0000_0000_0000));
        add_row(make_item(OP_JUDGE, '0, '0, '0, '0, '0, 8'hFF, '1));
        // overflow of kappa_bar*h0 gives an infinite width
        add_row(make_item(OP_RESET, '0, '0, '0, '0, '0, 8'd0, 64'h7FEF_FFFF_FFFF_FFFF),
                1'b1, VERDICT_REJECT, 64'h7FF0_0000_0000_0000);
        add_row(make_item(OP_RESUME, '0, '0, '0, '0, '0, 8'd0, dbl(1.0)));

        foreach (dir_rows[i]) begin
            exp_row.verdict      = dir_rows[i].verdict;
            exp_row.funnel_width = dir_rows[i].width;
            send_item(dir_rows[i].item, dir_rows[i].typed, exp_row);
        end
        s_valid <= 1'b0;

        // random phases, one register setting each
        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            no_idle = (p == 5);
            load_setting((p == 1) ? 1 : (p == 2) ? 2 : (p == 4) ? 4 : 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold off the sender until the core has emptied
                if (p == 3 && n == PHASE_ITEMS / 2) begin
                    s_valid <= 1'b0;
                    drain();
                end
                send_item(random_item(), 1'b0, exp_row);
            end
            s_valid <= 1'b0;
        end
        no_idle = 1'b0;

        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("funnel_step_acceptance_core regression: pass");
        end else begin
            $display("funnel_step_acceptance_core regression: fail");
        end
        $finish;
    end

endmodule
